### hdl/fue_pkg.sv
// ----------------------------------------------------------------------------
// fue_pkg
// Types, constants and byte-classification and byte-coding functions for the form encoder.
// ----------------------------------------------------------------------------
package fue_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;

  localparam int unsigned IDX_W    = 3;
  localparam logic [IDX_W-1:0] BRK_LAST = 3'd5;
  localparam logic [IDX_W-1:0] HEX_LAST = 3'd2;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_BYTE  = 2'd1,
    K_BREAK = 2'd2,
    K_HEX   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       pre_break;
    kind_t      kind;
    logic [7:0] data;
    logic       fin;
  } cmd_t;

  function automatic logic is_plain(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
    unique case (c)
      8'h21, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2D, 8'h2E, 8'h5F, 8'h7E: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else           r = 8'h37 + {4'd0, n};
    return r;
  endfunction

  function automatic logic [7:0] brk_byte(input logic [IDX_W-1:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0, 3'd3: r = CH_PCT;
      3'd1, 3'd4: r = 8'h30;
      3'd2:       r = 8'h44;
      default:    r = 8'h41;
    endcase
    return r;
  endfunction

endpackage

### hdl/fue_front.sv
// ----------------------------------------------------------------------------
// fue_front
// Accepts text bytes, tracks a held CR and turns each other byte into a command.
// ----------------------------------------------------------------------------
module fue_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_text_byte,
  input  logic          in_final_byte,
  input  logic          q_full,
  output logic          q_wr,
  output fue_pkg::cmd_t q_wdata
);
  import fue_pkg::*;

  logic  pending_cr_r, pending_cr_nxt;
  logic  accept;
  logic  pre;
  kind_t kind;
  logic [7:0] data;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign pre      = pending_cr_r & (in_text_byte != CH_LF);

  always_comb begin
    data = in_text_byte;
    if (in_text_byte == CH_CR) begin
      kind = in_final_byte ? K_BREAK : K_NONE;
    end else if (in_text_byte == CH_LF) begin
      kind = K_BREAK;
    end else if (is_plain(in_text_byte)) begin
      kind = K_BYTE;
    end else if (in_text_byte == CH_SPACE) begin
      kind = K_BYTE;
      data = CH_PLUS;
    end else begin
      kind = K_HEX;
    end
  end

  assign q_wdata.pre_break = pre;
  assign q_wdata.kind      = kind;
  assign q_wdata.data      = data;
  assign q_wdata.fin       = in_final_byte;
  assign q_wr              = accept & (pre | (kind != K_NONE));

  always_comb begin
    pending_cr_nxt = pending_cr_r;
    if (accept) pending_cr_nxt = (in_text_byte == CH_CR) & ~in_final_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pending_cr_r <= 1'b0;
    else        pending_cr_r <= pending_cr_nxt;
  end

endmodule

### hdl/fue_queue.sv
// ----------------------------------------------------------------------------
// fue_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fue_queue #(
  parameter int unsigned DEPTH = fue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  fue_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output fue_pkg::cmd_t rdata,
  output logic          empty
);
  import fue_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

endmodule

### hdl/fue_back.sv
// ----------------------------------------------------------------------------
// fue_back
// Expands the command at the queue head into output bytes, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module fue_back (
  input  logic          clk,
  input  logic          rst_n,
  input  fue_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_rd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_coded_byte,
  output logic          out_run_end,
  output logic          out_text_end
);
  import fue_pkg::*;

  logic             main_r, main_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             run_end_r, text_end_r;
  logic             in_pre, fire, last;
  logic [7:0]       cur;

  assign in_pre = head.pre_break & ~main_r;
  assign fire   = ~q_empty & (~valid_r | out_ready);
  assign q_rd   = fire & last;

  always_comb begin
    cur  = brk_byte(idx_r);
    last = 1'b0;
    if (in_pre) begin
      last = (idx_r == BRK_LAST) & (head.kind == K_NONE);
    end else begin
      unique case (head.kind)
        K_BYTE: begin
          cur  = head.data;
          last = 1'b1;
        end
        K_BREAK: last = (idx_r == BRK_LAST);
        K_HEX: begin
          last = (idx_r == HEX_LAST);
          priority case (idx_r)
            3'd0:    cur = CH_PCT;
            3'd1:    cur = hex_digit(head.data[7:4]);
            default: cur = hex_digit(head.data[3:0]);
          endcase
        end
        default: last = 1'b1;
      endcase
    end
  end

  always_comb begin
    main_nxt  = main_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r & ~out_ready;
    if (fire) begin
      valid_nxt = 1'b1;
      if (last) begin
        main_nxt = 1'b0;
        idx_nxt  = '0;
      end else if (in_pre && idx_r == BRK_LAST) begin
        main_nxt = 1'b1;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      main_r  <= main_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r     <= cur;
      run_end_r  <= last;
      text_end_r <= last & head.fin;
    end
  end

  assign out_valid      = valid_r;
  assign out_coded_byte = byte_r;
  assign out_run_end    = run_end_r;
  assign out_text_end   = text_end_r;

endmodule

### hdl/form_url_encoder_top.sv
// ----------------------------------------------------------------------------
// form_url_encoder_top
// Form (x-www-form-urlencoded) encoder, one text byte in, coded bytes out.
// ----------------------------------------------------------------------------
// Input channel: in_text_byte with in_final_byte marking the string's last
// byte, handshaken by in_valid/in_ready. Output channel: out_coded_byte with
// out_run_end on the last byte caused by an input and out_text_end on the
// last byte of the string, handshaken by out_valid/out_ready.
// The front classifies each byte and queues a command; the back expands it
// at one output byte per cycle while out_ready is high and the queue is not
// empty. A plain byte or space gives one output byte, an escaped byte three,
// a line break six, a break before another byte 6 to 12; a CR that is not
// final is held and gives nothing until the next byte settles it. The back's
// single output register sets the sustained rate; each command passes through
// the queue and then that register. The queue holds QUEUE_DEPTH commands, so
// the front keeps accepting while the receiver stalls until the queue fills;
// then in_ready drops. Reset clears the held CR, queue and output valid flag.
// ----------------------------------------------------------------------------
module form_url_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = fue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_coded_byte,
  output logic       out_run_end,
  output logic       out_text_end
);
  import fue_pkg::*;

  cmd_t q_wdata, q_rdata;
  logic q_wr, q_rd, q_full, q_empty;

  fue_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  fue_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  fue_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_rdata),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_coded_byte (out_coded_byte),
    .out_run_end    (out_run_end),
    .out_text_end   (out_text_end)
  );

endmodule

### hdl/fue_checker.sv
// ----------------------------------------------------------------------------
// fue_checker
// Port-level checks on the form encoder, bound to the top level.
// ----------------------------------------------------------------------------
module fue_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_coded_byte,
  input logic       out_run_end,
  input logic       out_text_end
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coded_byte)
      && $stable(out_run_end) && $stable(out_text_end))
    else $error("stalled output request changed");

  a_text_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_end)
    else $error("string end without run end");

  a_safe_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coded_byte != 8'h20 && out_coded_byte < 8'h80
      && out_coded_byte != 8'h0D && out_coded_byte != 8'h0A)
    else $error("unencoded byte on output");

endmodule

bind form_url_encoder_top fue_checker u_fue_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_coded_byte (out_coded_byte),
  .out_run_end    (out_run_end),
  .out_text_end   (out_text_end)
);

### tb/sv/form_url_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// form_url_encoder_top_tb
// Self-checking testbench for the form (x-www-form-urlencoded) encoder.
// Text bytes are offered over the input valid/ready channel. Each accepted
// byte is run through a local encoder that holds its own pending-CR flag,
// and the coded bytes it predicts are queued. Every coded byte leaving the
// block is checked, field by field, against the oldest queued prediction.
// Directed strings cover pass-through, space, escapes and CR/LF handling.
// Random strings, noise, a long receiver hold-off and a burst with no idling
// follow.
// ----------------------------------------------------------------------------
module form_url_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fue_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned RESET_CYCLES     = 11;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic [47:0] CRLF_ESCAPE      = "%0D%0A";

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       run_end;
    logic       text_end;
  } coded_result_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [7:0] in_text_byte  = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_ready     = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_coded_byte;
  logic       out_run_end;
  logic       out_text_end;

  coded_result_t expected_coded[$];
  coded_result_t want;
  coded_result_t seen;
  logic          cr_held = 1'b0;

  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned bytes_sent      = 0;
  int unsigned strings_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned hold_requests   = 0;
  int unsigned holds_served    = 0;
  int unsigned ready_stall     = 0;
  bit          sender_free     = 1'b0;
  bit          ready_free      = 1'b0;

  form_url_encoder_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_coded_byte(out_coded_byte),
    .out_run_end   (out_run_end),
    .out_text_end  (out_text_end)
  );

  always #4 clk = ~clk;

  function automatic bit passes_plain(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
           (c inside {"!", "'", "(", ")", "*", "-", ".", "_", "~"});
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
  endfunction

  function automatic void encode_text_byte(input logic [7:0] c, input logic fin);
    coded_result_t r;
    logic [7:0]    body[$];
    logic [7:0]    seq[$];
    int unsigned   n_brk;
    n_brk = (cr_held && c != CH_LF) ? 1 : 0;
    cr_held = 1'b0;
    if (passes_plain(c)) begin
      body.push_back(c);
    end else if (c == CH_SPACE) begin
      body.push_back(CH_PLUS);
    end else if (c == CH_LF || (c == CH_CR && fin)) begin
      n_brk++;
    end else if (c == CH_CR) begin
      cr_held = 1'b1;
    end else begin
      body.push_back(CH_PCT);
      body.push_back(nibble_char(c[7:4]));
      body.push_back(nibble_char(c[3:0]));
    end
    repeat (n_brk) begin
      for (int k = 5; k >= 0; k--) seq.push_back(CRLF_ESCAPE[8*k +: 8]);
    end
    foreach (body[i]) seq.push_back(body[i]);
    foreach (seq[i]) begin
      r.coded_byte = seq[i];
      r.run_end    = (i == seq.size() - 1);
      r.text_end   = r.run_end && fin;
      expected_coded.push_back(r);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      do c = 8'($urandom_range(0, 255)); while (!passes_plain(c));
    end else if (r < 40) begin
      c = CH_SPACE;
    end else if (r < 55) begin
      c = CH_CR;
    end else if (r < 70) begin
      c = CH_LF;
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic offer_text_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    encode_text_byte(b, fin);
    bytes_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic send_random_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) offer_text_byte(pick_text_byte(), i == len - 1);
  endtask

  task automatic test_pass_through();
    offer_text_byte("A", 1'b0);
    offer_text_byte("z", 1'b0);
    offer_text_byte("0", 1'b0);
    offer_text_byte("9", 1'b0);
    offer_text_byte("!", 1'b0);
    offer_text_byte("~", 1'b1);
  endtask

  task automatic test_space_and_escapes();
    offer_text_byte(CH_SPACE, 1'b0);
    offer_text_byte(8'h00, 1'b0);
    offer_text_byte(8'h7F, 1'b0);
    offer_text_byte(8'h80, 1'b0);
    offer_text_byte(8'hFF, 1'b1);
  endtask

  task automatic test_line_breaks();
    offer_text_byte(CH_LF, 1'b0);
    offer_text_byte(CH_CR, 1'b0);
    offer_text_byte(CH_LF, 1'b0);
    offer_text_byte(CH_CR, 1'b0);
    offer_text_byte("x", 1'b0);
    offer_text_byte(CH_CR, 1'b0);
    offer_text_byte(CH_CR, 1'b0);
    offer_text_byte("b", 1'b0);
    offer_text_byte(CH_CR, 1'b1);
    offer_text_byte(CH_CR, 1'b0);
    offer_text_byte(CH_CR, 1'b1);
  endtask

  task automatic test_random_strings();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < 220) begin
      if ($urandom_range(0, 7) == 0) send_random_string($urandom_range(1, 12));
      else send_random_string($urandom_range(1, 5));
    end
  endtask

  task automatic test_noise();
    logic [7:0] c;
    repeat (40) begin
      c = $urandom_range(0, 1) ? pick_text_byte() : 8'($urandom_range(0, 255));
      offer_text_byte(c, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_back_pressure();
    hold_requests++;
    sender_free = 1'b1;
    repeat (24) begin
      offer_text_byte($urandom_range(0, 1) ? CH_CR : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0);
    end
    sender_free = 1'b0;
  endtask

  task automatic test_full_rate_burst();
    int unsigned start;
    sender_free = 1'b1;
    ready_free  = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < 36) send_random_string($urandom_range(1, 6));
    sender_free = 1'b0;
    ready_free  = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      ready_stall  = LONG_HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_ready <= 1'b0;
    end else if (ready_free || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      ready_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.coded_byte = out_coded_byte;
      seen.run_end    = out_run_end;
      seen.text_end   = out_text_end;
      if (expected_coded.size() == 0) begin
        note_mismatch($sformatf("unexpected coded byte %02h run_end %0b text_end %0b",
                                seen.coded_byte, seen.run_end, seen.text_end));
      end else begin
        want = expected_coded.pop_front();
        results_checked++;
        if (seen.coded_byte !== want.coded_byte || seen.run_end !== want.run_end ||
            seen.text_end !== want.text_end) begin
          note_mismatch($sformatf("expected %02h/%0b/%0b got %02h/%0b/%0b",
                                  want.coded_byte, want.run_end, want.text_end,
                                  seen.coded_byte, seen.run_end, seen.text_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through();
    test_space_and_escapes();
    test_line_breaks();
    test_random_strings();
    test_noise();
    test_back_pressure();
    test_full_rate_burst();
    in_valid <= 1'b0;
    while (expected_coded.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_coded.size() != 0) note_mismatch("coded bytes still outstanding");
    $display("Sent %0d text bytes in %0d strings, checked %0d coded bytes.",
             bytes_sent, strings_sent, results_checked);
    $display("Covered plain, space, escapes, CR/LF folding, long hold-off and full-rate bursts.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
